// ----- design/bts_pkg.sv -----
package bts_pkg;

	typedef struct packed {
		logic               kind;
		logic [15:0]        texel_address;
		logic [7:0]         first_byte;
		logic [7:0]         second_byte;
		logic [7:0]         third_byte;
		logic signed [23:0] u_coord;
		logic signed [23:0] v_coord;
	} item_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} result_t;

	// Operands of the shared multiply-accumulate unit: acc = c + a * b.
	typedef struct packed {
		logic signed [25:0] a;
		logic signed [17:0] b;
		logic signed [43:0] c;
	} mac_op_t;

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_MUL_FX   = 13'b0000000000010,
		ST_MUL_FY   = 13'b0000000000100,
		ST_MUL_ROW0 = 13'b0000000001000,
		ST_MUL_ROW1 = 13'b0000000010000,
		ST_RD_C10   = 13'b0000000100000,
		ST_RD_C01   = 13'b0000001000000,
		ST_RD_C11   = 13'b0000010000000,
		ST_RD_WAIT  = 13'b0000100000000,
		ST_LERP_X0  = 13'b0001000000000,
		ST_LERP_X1  = 13'b0010000000000,
		ST_LERP_Y   = 13'b0100000000000,
		ST_FINISH   = 13'b1000000000000
	} state_t;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [1:0] CFG_IMAGE_WIDTH     = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT    = 2'd1;
	localparam logic [1:0] CFG_WRAP_MODE       = 2'd2;
	localparam logic [1:0] CFG_SOURCE_CHANNELS = 2'd3;

	localparam logic WRAP_REPEAT = 1'b0;
	localparam logic WRAP_CLAMP  = 1'b1;

	localparam logic [8:0] DIM_RESET      = 9'd256;
	localparam logic [2:0] CHANNELS_RESET = 3'd4;

	localparam int TEXEL_W     = 24;
	localparam int STORE_DEPTH = 65536;

endpackage

// ----- design/bts_ram.sv -----
module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/bts_mac.sv -----
module bts_mac (
	input  logic             clk,
	input  bts_pkg::mac_op_t op,
	output logic [43:0]      acc
);

	logic signed [43:0] acc_d;
	logic signed [43:0] acc_q;

	assign acc_d = op.c + op.a * op.b;

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
	end

	assign acc = acc_q;

endmodule

// ----- design/bilinear_texture_sampler.sv -----
// Texel writes are taken only while the block is idle and never raise busy.
// A sample keeps busy high through its whole sequence; its result strobe rises as busy falls,
// and no new item is taken while a sample runs. One shared multiply-accumulate unit does
// all 13 products and the single-ported texel RAM gives the four reads.
// Reset clears the sequencer and sets the registers to 256, 256, repeat and four channels;
// the texel RAM is not cleared. The result is shown for one cycle and cannot be stalled.
module bilinear_texture_sampler #(
	parameter int MAX_DIMENSION = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bts_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output bts_pkg::result_t result,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [8:0]       wr_data
);

	localparam int DimCap = (MAX_DIMENSION < 511) ? MAX_DIMENSION : 511;
	localparam logic [8:0] DIM_CAP = DimCap[8:0];

	bts_pkg::state_t state_q;
	bts_pkg::state_t state_d;

	logic [8:0]  width_q;
	logic [8:0]  height_q;
	logic        wrap_q;
	logic [2:0]  channels_q;

	logic [1:0]  chan_cnt_q;
	logic        done_q;

	logic [16:0] wu_q;
	logic [16:0] wv_q;
	logic [8:0]  dim_w_q;
	logic [8:0]  dim_h_q;
	logic [24:0] fx_q;
	logic [15:0] ty_q;
	logic [8:0]  y1_q;
	logic [15:0] base0_q;
	logic [15:0] base1_q;
	logic [23:0] tex_q [4];
	logic [23:0] r0_q;
	logic [15:0] chan_q [2];
	bts_pkg::result_t result_q;

	logic        accept;
	logic        accept_write;
	logic        accept_sample;
	logic [16:0] wu_in;
	logic [16:0] wv_in;
	logic [8:0]  x0;
	logic [8:0]  x1;
	logic [8:0]  y0;
	logic [15:0] tx;
	logic [43:0] mac_q;
	bts_pkg::mac_op_t mac_op;
	logic        ram_we;
	logic [15:0] ram_addr;
	logic [23:0] ram_wdata;
	logic [23:0] ram_rdata;
	logic [7:0]  ch00;
	logic [7:0]  ch10;
	logic [7:0]  ch01;
	logic [7:0]  ch11;
	logic [8:0]  diff_x;
	logic [24:0] diff_y;
	logic        chan_idx;

	function automatic logic [8:0] eff_dim(input logic [8:0] d);
		logic [8:0] r;
		r = d;
		if (d == 9'd0) begin
			r = 9'd1;
		end else if (d > DIM_CAP) begin
			r = DIM_CAP;
		end
		return r;
	endfunction

	// Repeat keeps the fraction; clamp saturates to 0 .. 1.0.
	function automatic logic [16:0] wrap_coord(input logic [23:0] c, input logic clamp);
		logic [16:0] r;
		r = {1'b0, c[15:0]};
		if (clamp == bts_pkg::WRAP_CLAMP) begin
			if (c[23]) begin
				r = 17'd0;
			end else if (c[22:16] != 7'd0) begin
				r = 17'h10000;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] pick(input logic [23:0] t, input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0:    r = t[7:0];
			2'd1:    r = t[15:8];
			default: r = t[23:16];
		endcase
		return r;
	endfunction

	assign busy          = (state_q != bts_pkg::ST_IDLE);
	assign accept        = start && !busy;
	assign accept_write  = accept && (item.kind == bts_pkg::KIND_WRITE);
	assign accept_sample = accept && (item.kind == bts_pkg::KIND_SAMPLE);

	assign wu_in = wrap_coord(item.u_coord, wrap_q);
	assign wv_in = wrap_coord(item.v_coord, wrap_q);

	// Both wrap modes keep the low corner inside the image, so the high
	// corner is one step further, held at the last texel.
	assign x0 = fx_q[24:16];
	assign x1 = (x0 == dim_w_q - 9'd1) ? x0 : x0 + 9'd1;
	assign y0 = mac_q[24:16];
	assign tx = fx_q[15:0];

	assign ch00 = pick(tex_q[0], chan_cnt_q);
	assign ch10 = pick(tex_q[1], chan_cnt_q);
	assign ch01 = pick(tex_q[2], chan_cnt_q);
	assign ch11 = pick(tex_q[3], chan_cnt_q);

	assign diff_y   = {1'b0, mac_q[23:0]} - {1'b0, r0_q};
	assign chan_idx = chan_cnt_q[0] ^ 1'b1;

	always_comb begin
		diff_x = 9'd0;
		mac_op = '0;
		case (state_q)
			bts_pkg::ST_MUL_FX: begin
				mac_op.a = {9'd0, wu_q};
				mac_op.b = {9'd0, dim_w_q - 9'd1};
			end
			bts_pkg::ST_MUL_FY: begin
				mac_op.a = {9'd0, wv_q};
				mac_op.b = {9'd0, dim_h_q - 9'd1};
			end
			bts_pkg::ST_MUL_ROW0: begin
				mac_op.a = {17'd0, y0};
				mac_op.b = {9'd0, dim_w_q};
			end
			bts_pkg::ST_MUL_ROW1: begin
				mac_op.a = {17'd0, y1_q};
				mac_op.b = {9'd0, dim_w_q};
			end
			bts_pkg::ST_LERP_X0: begin
				diff_x   = {1'b0, ch10} - {1'b0, ch00};
				mac_op.a = {{17{diff_x[8]}}, diff_x};
				mac_op.b = {2'd0, tx};
				mac_op.c = {20'd0, ch00, 16'd0};
			end
			bts_pkg::ST_LERP_X1: begin
				diff_x   = {1'b0, ch11} - {1'b0, ch01};
				mac_op.a = {{17{diff_x[8]}}, diff_x};
				mac_op.b = {2'd0, tx};
				mac_op.c = {20'd0, ch01, 16'd0};
			end
			bts_pkg::ST_LERP_Y: begin
				mac_op.a = {diff_y[24], diff_y};
				mac_op.b = {2'd0, ty_q};
				mac_op.c = {4'd0, r0_q, 16'd0};
			end
			default: begin
				mac_op = '0;
			end
		endcase
	end

	bts_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.acc (mac_q)
	);

	always_comb begin
		ram_we    = accept_write;
		ram_wdata = {item.first_byte, item.first_byte, item.first_byte};
		if (channels_q inside {3'd3, 3'd4}) begin
			ram_wdata = {item.third_byte, item.second_byte, item.first_byte};
		end
		case (state_q)
			bts_pkg::ST_MUL_ROW1: ram_addr = mac_q[15:0] + {7'd0, x0};
			bts_pkg::ST_RD_C10:   ram_addr = base0_q + {7'd0, x1};
			bts_pkg::ST_RD_C01:   ram_addr = base1_q + {7'd0, x0};
			bts_pkg::ST_RD_C11:   ram_addr = base1_q + {7'd0, x1};
			default:              ram_addr = item.texel_address;
		endcase
	end

	bts_ram #(
		.WIDTH (bts_pkg::TEXEL_W),
		.DEPTH (bts_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bts_pkg::ST_IDLE:     if (accept_sample) state_d = bts_pkg::ST_MUL_FX;
			bts_pkg::ST_MUL_FX:   state_d = bts_pkg::ST_MUL_FY;
			bts_pkg::ST_MUL_FY:   state_d = bts_pkg::ST_MUL_ROW0;
			bts_pkg::ST_MUL_ROW0: state_d = bts_pkg::ST_MUL_ROW1;
			bts_pkg::ST_MUL_ROW1: state_d = bts_pkg::ST_RD_C10;
			bts_pkg::ST_RD_C10:   state_d = bts_pkg::ST_RD_C01;
			bts_pkg::ST_RD_C01:   state_d = bts_pkg::ST_RD_C11;
			bts_pkg::ST_RD_C11:   state_d = bts_pkg::ST_RD_WAIT;
			bts_pkg::ST_RD_WAIT:  state_d = bts_pkg::ST_LERP_X0;
			bts_pkg::ST_LERP_X0:  state_d = bts_pkg::ST_LERP_X1;
			bts_pkg::ST_LERP_X1:  state_d = bts_pkg::ST_LERP_Y;
			bts_pkg::ST_LERP_Y: begin
				state_d = (chan_cnt_q == 2'd2) ? bts_pkg::ST_FINISH : bts_pkg::ST_LERP_X0;
			end
			bts_pkg::ST_FINISH:   state_d = bts_pkg::ST_IDLE;
			default:              state_d = bts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bts_pkg::ST_IDLE;
			chan_cnt_q <= 2'd0;
			done_q     <= 1'b0;
			width_q    <= bts_pkg::DIM_RESET;
			height_q   <= bts_pkg::DIM_RESET;
			wrap_q     <= bts_pkg::WRAP_REPEAT;
			channels_q <= bts_pkg::CHANNELS_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == bts_pkg::ST_FINISH);
			if (state_q == bts_pkg::ST_RD_WAIT) begin
				chan_cnt_q <= 2'd0;
			end else if (state_q == bts_pkg::ST_LERP_Y) begin
				chan_cnt_q <= chan_cnt_q + 2'd1;
			end
			if (wr_en) begin
				case (wr_index)
					bts_pkg::CFG_IMAGE_WIDTH:     width_q    <= wr_data;
					bts_pkg::CFG_IMAGE_HEIGHT:    height_q   <= wr_data;
					bts_pkg::CFG_WRAP_MODE:       wrap_q     <= wr_data[0];
					bts_pkg::CFG_SOURCE_CHANNELS: channels_q <= wr_data[2:0];
					default:                      wrap_q     <= wrap_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_sample) begin
			wu_q    <= wu_in;
			wv_q    <= wv_in;
			dim_w_q <= eff_dim(width_q);
			dim_h_q <= eff_dim(height_q);
		end
		case (state_q)
			bts_pkg::ST_MUL_FY: begin
				fx_q <= mac_q[24:0];
			end
			bts_pkg::ST_MUL_ROW0: begin
				ty_q <= mac_q[15:0];
				y1_q <= (y0 == dim_h_q - 9'd1) ? y0 : y0 + 9'd1;
			end
			bts_pkg::ST_MUL_ROW1: begin
				base0_q <= mac_q[15:0];
			end
			bts_pkg::ST_RD_C10: begin
				base1_q  <= mac_q[15:0];
				tex_q[0] <= ram_rdata;
			end
			bts_pkg::ST_RD_C01: begin
				tex_q[1] <= ram_rdata;
			end
			bts_pkg::ST_RD_C11: begin
				tex_q[2] <= ram_rdata;
			end
			bts_pkg::ST_RD_WAIT: begin
				tex_q[3] <= ram_rdata;
			end
			bts_pkg::ST_LERP_X0: begin
				// The previous channel's vertical blend has just landed.
				if (chan_cnt_q != 2'd0) begin
					chan_q[chan_idx] <= mac_q[39:24];
				end
			end
			bts_pkg::ST_LERP_X1: begin
				r0_q <= mac_q[23:0];
			end
			bts_pkg::ST_FINISH: begin
				result_q.red   <= chan_q[0];
				result_q.green <= chan_q[1];
				result_q.blue  <= mac_q[39:24];
			end
			default: begin
				r0_q <= r0_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == bts_pkg::ST_FINISH))
		else $error("result strobe without a finished blend");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result word is shown");

	a_sample_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind == bts_pkg::KIND_SAMPLE) |=> busy)
		else $error("accepted sample did not start the sequencer");

	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind == bts_pkg::KIND_WRITE) |=> (!busy && !done))
		else $error("texel write disturbed the sequencer");

endmodule

// ----- dv/bilinear_texture_sampler_test.sv -----
`timescale 1ns / 100ps

localparam int MAX_DIM = 256;

class texture_scoreboard;
	logic [23:0]       texels [bts_pkg::STORE_DEPTH];
	bit                written [bts_pkg::STORE_DEPTH];
	logic [8:0]        width_reg;
	logic [8:0]        height_reg;
	logic              wrap_reg;
	logic [2:0]        chan_reg;
	bts_pkg::result_t  expected_colors [$];
	int                failures;

	function new();
		width_reg  = bts_pkg::DIM_RESET;
		height_reg = bts_pkg::DIM_RESET;
		wrap_reg   = bts_pkg::WRAP_REPEAT;
		chan_reg   = bts_pkg::CHANNELS_RESET;
		failures   = 0;
	endfunction

	function void configure(logic [1:0] index, logic [8:0] value);
		case (index)
			bts_pkg::CFG_IMAGE_WIDTH:     width_reg = value;
			bts_pkg::CFG_IMAGE_HEIGHT:    height_reg = value;
			bts_pkg::CFG_WRAP_MODE:       wrap_reg = value[0];
			bts_pkg::CFG_SOURCE_CHANNELS: chan_reg = value[2:0];
			default: ;
		endcase
	endfunction

	function logic [31:0] eff_dim(logic [8:0] d);
		if (d == 9'd0)
			return 32'd1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return {23'd0, d};
	endfunction

	// Q8.16 coordinate to Q1.16 in the range 0 to 1.0 inclusive.
	function logic [16:0] wrap_coord(logic signed [23:0] c);
		if (wrap_reg == bts_pkg::WRAP_REPEAT)
			return {1'b0, c[15:0]};
		if (c[23])
			return 17'd0;
		if (c[22:16] != 7'd0)
			return 17'h10000;
		return {1'b0, c[15:0]};
	endfunction

	function logic [31:0] wrap_index(logic [31:0] i, logic [31:0] dim);
		if (wrap_reg == bts_pkg::WRAP_REPEAT)
			return i % dim;
		return (i > dim - 1) ? dim - 1 : i;
	endfunction

	function logic [15:0] store_index(logic [31:0] x, logic [31:0] y, logic [31:0] w);
		logic [31:0] flat;
		flat = y * w + x;
		return flat[15:0];
	endfunction

	// Corners in the order top-left, top-right, bottom-left, bottom-right.
	function void locate_corners(input logic signed [23:0] u, input logic signed [23:0] v,
			output logic [3:0][15:0] addr, output logic [15:0] tx, output logic [15:0] ty);
		logic [31:0] w, h, fx, fy, x0, x1, y0, y1;
		w = eff_dim(width_reg);
		h = eff_dim(height_reg);
		fx = wrap_coord(u) * (w - 1);
		fy = wrap_coord(v) * (h - 1);
		tx = fx[15:0];
		ty = fy[15:0];
		x0 = wrap_index({16'd0, fx[31:16]}, w);
		x1 = wrap_index({16'd0, fx[31:16]} + 1, w);
		y0 = wrap_index({16'd0, fy[31:16]}, h);
		y1 = wrap_index({16'd0, fy[31:16]} + 1, h);
		addr[0] = store_index(x0, y0, w);
		addr[1] = store_index(x1, y0, w);
		addr[2] = store_index(x0, y1, w);
		addr[3] = store_index(x1, y1, w);
	endfunction

	function void note_item(bts_pkg::item_t it);
		logic [7:0]        r, g, b;
		logic [3:0][15:0]  addr;
		logic [15:0]       tx, ty;
		logic [23:0]       t00, t10, t01, t11;
		logic [63:0]       row0, row1, col;
		logic [2:0][15:0]  chan;
		bts_pkg::result_t  want;
		if (it.kind == bts_pkg::KIND_WRITE) begin
			r = it.first_byte;
			g = r;
			b = r;
			if (chan_reg inside {3'd3, 3'd4}) begin
				g = it.second_byte;
				b = it.third_byte;
			end
			texels[it.texel_address] = {b, g, r};
			written[it.texel_address] = 1'b1;
			return;
		end
		locate_corners(it.u_coord, it.v_coord, addr, tx, ty);
		t00 = texels[addr[0]];
		t10 = texels[addr[1]];
		t01 = texels[addr[2]];
		t11 = texels[addr[3]];
		for (int k = 0; k < 3; k++) begin
			row0 = t00[8*k +: 8] * (64'h10000 - tx) + t10[8*k +: 8] * tx;
			row1 = t01[8*k +: 8] * (64'h10000 - tx) + t11[8*k +: 8] * tx;
			col = row0 * (64'h10000 - ty) + row1 * ty;
			chan[k] = col[39:24];
		end
		want.red = chan[0];
		want.green = chan[1];
		want.blue = chan[2];
		expected_colors.push_back(want);
	endfunction

	function void check_result(bts_pkg::result_t got);
		bts_pkg::result_t want;
		bit               bad;
		if (expected_colors.size() == 0) begin
			$display("%0t: unexpected result %h with no sample pending", $time, got);
			failures++;
			return;
		end
		want = expected_colors.pop_front();
		bad = 1'b0;
		if (got.red !== want.red) begin
			$display("%0t: red expected %h, got %h", $time, want.red, got.red);
			bad = 1'b1;
		end
		if (got.green !== want.green) begin
			$display("%0t: green expected %h, got %h", $time, want.green, got.green);
			bad = 1'b1;
		end
		if (got.blue !== want.blue) begin
			$display("%0t: blue expected %h, got %h", $time, want.blue, got.blue);
			bad = 1'b1;
		end
		if (bad)
			failures++;
	endfunction
endclass

module bilinear_texture_sampler_test;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 93;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	bts_pkg::item_t   item = '0;
	logic             busy;
	logic             done;
	bts_pkg::result_t result;
	logic             wr_en = 1'b0;
	logic [1:0]       wr_index = bts_pkg::CFG_IMAGE_WIDTH;
	logic [8:0]       wr_data = '0;

	texture_scoreboard board;
	int items_sent = 0;
	int cycles = 0;
	bit gaps_on = 1'b0;

	logic signed [23:0] extreme_coords [7] = '{24'sh000000, 24'sh7FFFFF, 24'sh800000,
		24'shFFFFFF, 24'sh010000, 24'sh00FFFF, 24'sh008000};

	bilinear_texture_sampler #(.MAX_DIMENSION(MAX_DIM)) DUT (
		.clk,
		.arst_n,
		.start,
		.item,
		.busy,
		.done,
		.result,
		.wr_en,
		.wr_index,
		.wr_data
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	function automatic bts_pkg::item_t scrambled_item();
		logic [95:0] noise;
		noise = {$urandom, $urandom, $urandom};
		return noise[$bits(bts_pkg::item_t)-1:0];
	endfunction

	function automatic logic signed [23:0] pick_coord();
		logic [31:0] r;
		case ($urandom_range(0, 5))
			0, 1: r = $urandom;
			2, 3: r = $urandom_range(0, 65536);
			4: r = {8'd0, extreme_coords[$urandom_range(0, 6)]};
			default: r = 32'd0 - $urandom_range(1, 65536);
		endcase
		return r[23:0];
	endfunction

	// Holds the word on the bus until the block takes it.
	task automatic push_item(input bts_pkg::item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		board.note_item(it);
		items_sent++;
	endtask

	task automatic write_texel(input logic [15:0] addr, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		bts_pkg::item_t it;
		it = scrambled_item();
		it.kind = bts_pkg::KIND_WRITE;
		it.texel_address = addr;
		it.first_byte = r;
		it.second_byte = g;
		it.third_byte = b;
		push_item(it);
	endtask

	// Any corner that was never written gets a texel first.
	task automatic sample_at(input logic signed [23:0] u, input logic signed [23:0] v);
		bts_pkg::item_t   it;
		logic [3:0][15:0] addr;
		logic [15:0]      tx, ty;
		board.locate_corners(u, v, addr, tx, ty);
		for (int i = 0; i < 4; i++) begin
			if (!board.written[addr[i]])
				write_texel(addr[i], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
		end
		it = scrambled_item();
		it.kind = bts_pkg::KIND_SAMPLE;
		it.u_coord = u;
		it.v_coord = v;
		push_item(it);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (board.expected_colors.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// Unused upper data bits carry noise; the narrow registers must ignore them.
	task automatic program_image(input logic [8:0] w, input logic [8:0] h,
			input logic mode, input logic [2:0] ch);
		logic [1:0] index [4];
		logic [8:0] value [4];
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		index[0] = bts_pkg::CFG_IMAGE_WIDTH;
		index[1] = bts_pkg::CFG_IMAGE_HEIGHT;
		index[2] = bts_pkg::CFG_WRAP_MODE;
		index[3] = bts_pkg::CFG_SOURCE_CHANNELS;
		value[0] = w;
		value[1] = h;
		value[2] = {junk, mode};
		value[3] = {junk[5:0], ch};
		for (int i = 0; i < 4; i++) begin
			wr_en <= 1'b1;
			wr_index <= index[i];
			wr_data <= value[i];
			@(posedge clk);
			board.configure(index[i], value[i]);
		end
		wr_en <= 1'b0;
	endtask

	initial begin
		logic [8:0]  w_cfg, h_cfg;
		logic        mode_cfg;
		logic [2:0]  ch_cfg;
		logic [31:0] span;
		int          goal;
		int          pick;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions: a sample in the middle of the 256 by 256 image.
		sample_at(24'sh008000, 24'sh018000);
		settle();

		program_image(9'd2, 9'd2, bts_pkg::WRAP_REPEAT, 3'd4);
		write_texel(16'd0, 8'hFF, 8'h00, 8'h80);
		write_texel(16'd1, 8'h00, 8'hFF, 8'h01);
		write_texel(16'd2, 8'h11, 8'h22, 8'hFF);
		write_texel(16'd3, 8'h7F, 8'h80, 8'h00);
		write_texel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		for (int i = 0; i < 7; i++)
			sample_at(extreme_coords[i], extreme_coords[(i + 2) % 7]);
		settle();

		// Clamp with a single source channel, so the rewritten texel is gray.
		program_image(9'd2, 9'd2, bts_pkg::WRAP_CLAMP, 3'd1);
		write_texel(16'd3, 8'hC8, 8'h00, 8'hFF);
		for (int i = 0; i < 7; i++)
			sample_at(extreme_coords[i], extreme_coords[(i + 4) % 7]);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: program_image(9'd1, 9'd1, bts_pkg::WRAP_REPEAT, 3'd3);
				1: program_image(9'd256, 9'd256, bts_pkg::WRAP_CLAMP, 3'd0);
				2: program_image(9'd0, 9'd0, bts_pkg::WRAP_REPEAT, 3'd5);
				3: program_image(9'd511, 9'd300, bts_pkg::WRAP_CLAMP, 3'd7);
				4: program_image(9'd2, 9'd256, bts_pkg::WRAP_REPEAT, 3'd1);
				5: program_image(9'd256, 9'd1, bts_pkg::WRAP_CLAMP, 3'd2);
				6: program_image(9'd3, 9'd7, bts_pkg::WRAP_CLAMP, 3'd6);
				default: begin
					w_cfg = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
						: 9'($urandom_range(1, 16));
					h_cfg = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
						: 9'($urandom_range(1, 16));
					mode_cfg = 1'($urandom_range(0, 1));
					ch_cfg = 3'($urandom_range(0, 7));
					program_image(w_cfg, h_cfg, mode_cfg, ch_cfg);
				end
			endcase
			gaps_on = (p < PHASES - 2) && (p % 3 != 2);
			goal = items_sent + PHASE_ITEMS;
			span = board.eff_dim(board.width_reg) * board.eff_dim(board.height_reg);
			while (items_sent < goal) begin
				pick = $urandom_range(0, 9);
				if (pick <= 5)
					sample_at(pick_coord(), pick_coord());
				else if (pick <= 8)
					write_texel(16'($urandom_range(0, span - 1)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				else
					write_texel(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 59) == 0)
					settle();
			end
		end

		settle();
		if (board.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/bts_pkg.sv
design/bts_ram.sv
design/bts_mac.sv
design/bilinear_texture_sampler.sv
dv/bilinear_texture_sampler_test.sv
